>>> design/swrms_pkg.sv
// Shared constants, transaction types and state encodings of the sliding-window RMS detector.
package swrms_pkg;

  // Ring capacity and sample width.
  localparam int CAPACITY    = 1024;
  localparam int SAMPLE_BITS = 16;

  // Fixed field widths.
  localparam int WIN_W      = 11;
  localparam int RMS_W      = 16;
  localparam int WIN_RESET  = 256;

  // Derived widths.
  localparam int ADDR_W  = $clog2(CAPACITY);
  localparam int WEFF_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W   = (WIN_W > WEFF_W) ? WIN_W : WEFF_W;
  localparam int SQ_W    = 2 * SAMPLE_BITS - 1;
  localparam int SUM_W   = SQ_W + ADDR_W;
  localparam int ROOT_W  = SAMPLE_BITS;
  localparam int RAD_W   = 2 * ROOT_W;
  localparam int CNT_W   = $clog2(SUM_W);

  // Queue between front and back.
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // One job for the back end: the updated window sum and the window length.
  typedef struct packed {
    logic [SUM_W-1:0]  sum;
    logic [WEFF_W-1:0] win;
    logic              last;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_RD   = 3'b010,
    F_PUSH = 3'b100
  } front_state_t;

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_DIV  = 4'b0010,
    B_SQRT = 4'b0100,
    B_OUT  = 4'b1000
  } back_state_t;

endpackage

>>> design/swrms_in_if.sv
// Sample channel: one audio sample and its block-end flag per transaction.
interface swrms_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [swrms_pkg::SAMPLE_BITS-1:0] sample;
  logic                                  last_in_block;

  modport source (output valid, output sample, output last_in_block, input ready);
  modport sink   (input valid, input sample, input last_in_block, output ready);
endinterface

>>> design/swrms_out_if.sv
// Result channel: one RMS level and its block-end flag per transaction.
interface swrms_out_if;
  logic                           valid;
  logic                           ready;
  logic [swrms_pkg::RMS_W-1:0]    rms_level;
  logic                           block_done;

  modport source (output valid, output rms_level, output block_done, input ready);
  modport sink   (input valid, input rms_level, input block_done, output ready);
endinterface

>>> design/swrms_cfg_if.sv
// Configuration channel: writes of the window length register.
interface swrms_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [swrms_pkg::WIN_W-1:0]    win_len;

  modport source (output valid, output win_len, input ready);
  modport sink   (input valid, input win_len, output ready);
endinterface

>>> design/sliding_window_rms.sv
// Top level of the moving-window RMS level detector.
//
//   channel  | role   | transaction carries
//   ---------+--------+---------------------------------------------
//   in_ch    | sink   | sample (signed), last_in_block
//   out_ch   | source | rms_level, block_done
//   cfg_ch   | sink   | win_len (always ready)
//
// The front end handles one sample at a time: square and ring read, ring write
// with sum add, then subtract of the oldest square and hand-off to the job
// queue, held while it is full. The back end takes one job at a time: it pops
// it, runs the SUM_W (41) bit divide and ROOT_W (16) bit square root, and holds
// the result until taken. Reset, and any window write, clear the sum and the
// ring position at once; the ring itself needs no clearing pass because
// entries are only read back after the position has wrapped. A stalled result
// holds the back end, while the two queue slots and the front end's hand-off
// stage let it take up to three more samples before in_ch.ready stays low.
module sliding_window_rms (
  input  logic        clk,
  input  logic        rst_n,
  swrms_in_if.sink    in_ch,
  swrms_out_if.source out_ch,
  swrms_cfg_if.sink   cfg_ch
);

  // Front end to queue.
  logic               q_push;
  swrms_pkg::job_t    q_push_job;

  // Queue to back end.
  logic               q_pop;
  swrms_pkg::job_t    q_pop_job;
  swrms_pkg::q_stat_t q_stat;

  // The front end owns the window register, the ring RAM and the running sum.
  swrms_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_ch     (cfg_ch),
    .q_stat     (q_stat),
    .push_valid (q_push),
    .push_job   (q_push_job)
  );

  // Each job holds the new window sum and the clamped window length, so the
  // back end never looks at front-end state.
  swrms_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_push_job),
    .pop      (q_pop),
    .pop_job  (q_pop_job),
    .q_stat   (q_stat)
  );

  // The back end divides by the window, takes the floor square root and
  // holds the result until the output transaction completes.
  swrms_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_stat  (q_stat),
    .pop_job (q_pop_job),
    .pop     (q_pop),
    .out_ch  (out_ch)
  );

  // The queue status never reports full and empty together.
  a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("job queue reports full and empty at once");

  // A job taken from the queue starts a computation, so no result is shown next.
  a_pop_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> !out_ch.valid)
    else $error("result shown right after a job was popped");

  // The front end handles one sample at a time.
  a_front_single: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("front end ready right after taking a sample");

  // The front end never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("push into a full job queue");

endmodule

>>> design/swrms_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module swrms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> design/swrms_front.sv
// Front end: takes samples, squares them and keeps the ring of squares and the running sum.
module swrms_front (
  input  logic                clk,
  input  logic                rst_n,
  swrms_in_if.sink            in_ch,
  swrms_cfg_if.sink           cfg_ch,
  input  swrms_pkg::q_stat_t  q_stat,
  output logic                push_valid,
  output swrms_pkg::job_t     push_job
);

  swrms_pkg::front_state_t state_r, state_nxt;

  logic [swrms_pkg::WIN_W-1:0]       window_r;
  logic [swrms_pkg::ADDR_W-1:0]      pos_r;
  logic                              filled_r;
  logic [swrms_pkg::SUM_W-1:0]       sum_r;
  logic [swrms_pkg::SQ_W-1:0]        sq_r;
  logic [swrms_pkg::SQ_W-1:0]        old_r;
  logic                              last_r;

  logic                              accept;
  logic                              cfg_wr;
  logic [swrms_pkg::SAMPLE_BITS-1:0] raw;
  logic [swrms_pkg::SAMPLE_BITS-1:0] mag;
  logic [2*swrms_pkg::SAMPLE_BITS-1:0] prod;
  logic [swrms_pkg::CMP_W-1:0]       win_cmp;
  logic [swrms_pkg::WEFF_W-1:0]      w_eff;
  logic [swrms_pkg::WEFF_W-1:0]      pos_inc;
  logic                              wrap;
  logic [swrms_pkg::SQ_W-1:0]        rd_data;
  logic [swrms_pkg::SUM_W-1:0]       diff;

  assign in_ch.ready  = (state_r == swrms_pkg::F_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign accept       = in_ch.valid && in_ch.ready;
  assign cfg_wr       = cfg_ch.valid && cfg_ch.ready;

  // Magnitude of the two's complement sample; full-scale negative maps to 2^(N-1).
  assign raw  = in_ch.sample;
  assign mag  = raw[swrms_pkg::SAMPLE_BITS-1]
              ? (~raw + {{(swrms_pkg::SAMPLE_BITS-1){1'b0}}, 1'b1}) : raw;
  assign prod = {{swrms_pkg::SAMPLE_BITS{1'b0}}, mag}
              * {{swrms_pkg::SAMPLE_BITS{1'b0}}, mag};

  // Window length clamped to 1..CAPACITY.
  assign win_cmp = swrms_pkg::CMP_W'(window_r);
  always_comb begin
    if (win_cmp == '0) begin
      w_eff = swrms_pkg::WEFF_W'(1);
    end else if (win_cmp > swrms_pkg::CMP_W'(swrms_pkg::CAPACITY)) begin
      w_eff = swrms_pkg::WEFF_W'(swrms_pkg::CAPACITY);
    end else begin
      w_eff = swrms_pkg::WEFF_W'(win_cmp);
    end
  end

  assign pos_inc = swrms_pkg::WEFF_W'(pos_r) + swrms_pkg::WEFF_W'(1);
  assign wrap    = (pos_inc == w_eff);

  // The ring is only read back after the position has wrapped once since the
  // last clear, so entries before that read as zero without a clearing pass.
  swrms_ram #(
    .WIDTH (swrms_pkg::SQ_W),
    .DEPTH (swrms_pkg::CAPACITY)
  ) u_ring (
    .clk     (clk),
    .wr_en   (state_r == swrms_pkg::F_RD),
    .wr_addr (pos_r),
    .wr_data (sq_r),
    .rd_en   (accept),
    .rd_addr (pos_r),
    .rd_data (rd_data)
  );

  assign diff       = sum_r - swrms_pkg::SUM_W'(old_r);
  assign push_valid = (state_r == swrms_pkg::F_PUSH) && !q_stat.full;
  assign push_job   = '{sum: diff, win: w_eff, last: last_r};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      swrms_pkg::F_IDLE: begin
        if (accept) begin
          state_nxt = swrms_pkg::F_RD;
        end
      end
      swrms_pkg::F_RD: begin
        state_nxt = swrms_pkg::F_PUSH;
      end
      swrms_pkg::F_PUSH: begin
        if (!q_stat.full) begin
          state_nxt = swrms_pkg::F_IDLE;
        end
      end
      default: begin
        state_nxt = swrms_pkg::F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= swrms_pkg::F_IDLE;
      window_r <= swrms_pkg::WIN_W'(swrms_pkg::WIN_RESET);
      pos_r    <= '0;
      filled_r <= 1'b0;
      sum_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        window_r <= cfg_ch.win_len;
        pos_r    <= '0;
        filled_r <= 1'b0;
        sum_r    <= '0;
      end else if (state_r == swrms_pkg::F_RD) begin
        sum_r <= sum_r + swrms_pkg::SUM_W'(sq_r);
        if (wrap) begin
          pos_r    <= '0;
          filled_r <= 1'b1;
        end else begin
          pos_r <= swrms_pkg::ADDR_W'(pos_inc);
        end
      end else if (push_valid) begin
        sum_r <= diff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sq_r   <= prod[swrms_pkg::SQ_W-1:0];
      last_r <= in_ch.last_in_block;
    end
    if (state_r == swrms_pkg::F_RD) begin
      old_r <= filled_r ? rd_data : '0;
    end
  end

endmodule

>>> design/swrms_queue.sv
// Short job queue between the front end and the divide and square-root back end.
module swrms_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  swrms_pkg::job_t    push_job,
  input  logic               pop,
  output swrms_pkg::job_t    pop_job,
  output swrms_pkg::q_stat_t q_stat
);

  swrms_pkg::job_t              slot_r [swrms_pkg::QDEPTH];
  logic [swrms_pkg::QPTR_W-1:0] wptr_r;
  logic [swrms_pkg::QPTR_W-1:0] rptr_r;
  logic [swrms_pkg::QCNT_W-1:0] count_r;

  function automatic logic [swrms_pkg::QPTR_W-1:0] ptr_inc(
    input logic [swrms_pkg::QPTR_W-1:0] p
  );
    if (p == swrms_pkg::QPTR_W'(swrms_pkg::QDEPTH - 1)) begin
      return '0;
    end
    return p + swrms_pkg::QPTR_W'(1);
  endfunction

  assign q_stat.empty = (count_r == '0);
  assign q_stat.full  = (count_r == swrms_pkg::QCNT_W'(swrms_pkg::QDEPTH));
  assign pop_job      = slot_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= ptr_inc(wptr_r);
      end
      if (pop) begin
        rptr_r <= ptr_inc(rptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + swrms_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - swrms_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_job;
    end
  end

endmodule

>>> design/swrms_back.sv
// Back end: bit-serial divide of the window sum, digit-serial square root, result register.
module swrms_back (
  input  logic               clk,
  input  logic               rst_n,
  input  swrms_pkg::q_stat_t q_stat,
  input  swrms_pkg::job_t    pop_job,
  output logic               pop,
  swrms_out_if.source        out_ch
);

  swrms_pkg::back_state_t state_r, state_nxt;

  logic [swrms_pkg::CNT_W-1:0]  cnt_r;
  logic [swrms_pkg::WEFF_W-1:0] d_r;
  logic [swrms_pkg::WEFF_W-1:0] rem_r;
  logic [swrms_pkg::SUM_W-1:0]  dq_r;
  logic [swrms_pkg::RAD_W-1:0]  rad_r;
  logic [swrms_pkg::ROOT_W-1:0] srem_r;
  logic [swrms_pkg::ROOT_W-1:0] root_r;
  logic [swrms_pkg::RMS_W-1:0]  rms_r;
  logic                         last_r;
  logic                         done_r;

  logic [swrms_pkg::WEFF_W:0]   trial;
  logic [swrms_pkg::WEFF_W:0]   trial_sub;
  logic                         q_bit;
  logic [swrms_pkg::WEFF_W-1:0] rem_nxt;
  logic [swrms_pkg::SUM_W-1:0]  dq_nxt;
  logic [swrms_pkg::ROOT_W+1:0] s_cur;
  logic [swrms_pkg::ROOT_W+1:0] s_trial;
  logic [swrms_pkg::ROOT_W+1:0] s_sub;
  logic                         r_bit;
  logic [swrms_pkg::ROOT_W-1:0] srem_nxt;
  logic [swrms_pkg::ROOT_W-1:0] root_nxt;

  assign pop = (state_r == swrms_pkg::B_IDLE) && !q_stat.empty;

  // Restoring division, one quotient bit per cycle, MSB first.
  assign trial     = {rem_r, dq_r[swrms_pkg::SUM_W-1]};
  assign trial_sub = trial - {1'b0, d_r};
  assign q_bit     = (trial >= {1'b0, d_r});
  assign rem_nxt   = q_bit ? trial_sub[swrms_pkg::WEFF_W-1:0] : trial[swrms_pkg::WEFF_W-1:0];
  assign dq_nxt    = {dq_r[swrms_pkg::SUM_W-2:0], q_bit};

  // Square root, one root bit per cycle from the top pair of radicand bits.
  assign s_cur    = {srem_r, rad_r[swrms_pkg::RAD_W-1 -: 2]};
  assign s_trial  = {root_r, 2'b01};
  assign s_sub    = s_cur - s_trial;
  assign r_bit    = (s_cur >= s_trial);
  assign srem_nxt = r_bit ? s_sub[swrms_pkg::ROOT_W-1:0] : s_cur[swrms_pkg::ROOT_W-1:0];
  assign root_nxt = {root_r[swrms_pkg::ROOT_W-2:0], r_bit};

  assign out_ch.valid      = (state_r == swrms_pkg::B_OUT);
  assign out_ch.rms_level  = rms_r;
  assign out_ch.block_done = done_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      swrms_pkg::B_IDLE: begin
        if (pop) begin
          state_nxt = swrms_pkg::B_DIV;
        end
      end
      swrms_pkg::B_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = swrms_pkg::B_SQRT;
        end
      end
      swrms_pkg::B_SQRT: begin
        if (cnt_r == '0) begin
          state_nxt = swrms_pkg::B_OUT;
        end
      end
      swrms_pkg::B_OUT: begin
        if (out_ch.ready) begin
          state_nxt = swrms_pkg::B_IDLE;
        end
      end
      default: begin
        state_nxt = swrms_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= swrms_pkg::B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      swrms_pkg::B_IDLE: begin
        if (pop) begin
          rem_r  <= '0;
          dq_r   <= pop_job.sum;
          d_r    <= pop_job.win;
          last_r <= pop_job.last;
          cnt_r  <= swrms_pkg::CNT_W'(swrms_pkg::SUM_W - 1);
        end
      end
      swrms_pkg::B_DIV: begin
        rem_r <= rem_nxt;
        dq_r  <= dq_nxt;
        if (cnt_r == '0) begin
          rad_r  <= swrms_pkg::RAD_W'(dq_nxt[swrms_pkg::SQ_W-1:0]);
          srem_r <= '0;
          root_r <= '0;
          cnt_r  <= swrms_pkg::CNT_W'(swrms_pkg::ROOT_W - 1);
        end else begin
          cnt_r <= cnt_r - swrms_pkg::CNT_W'(1);
        end
      end
      swrms_pkg::B_SQRT: begin
        rad_r  <= {rad_r[swrms_pkg::RAD_W-3:0], 2'b00};
        srem_r <= srem_nxt;
        root_r <= root_nxt;
        cnt_r  <= cnt_r - swrms_pkg::CNT_W'(1);
        if (cnt_r == '0) begin
          rms_r  <= swrms_pkg::RMS_W'(root_nxt);
          done_r <= last_r;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
